FILE: rtl/float32_square_root_assert.svh
// Assertion macros for the float32 square root block.
// Included by the top level; no other dependencies.
`ifndef FLOAT32_SQUARE_ROOT_ASSERT_SVH
`define FLOAT32_SQUARE_ROOT_ASSERT_SVH
`ifndef ASSERT_OFF
`define FSQ_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define FSQ_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define FSQ_ASSERT_IMPL(label, clk, rst_n, prop)
`define FSQ_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: rtl/fsqrt_pkg.sv
// Shared types and constants for the float32 square root block.
// No dependencies.
`timescale 1ns / 1ps
package fsqrt_pkg;
    localparam int unsigned NumSteps = 27;
    localparam int unsigned RemW     = 29;
    localparam logic [31:0] RootNegNan = 32'hFFC00000;
    localparam logic [31:0] RootPosInf = 32'h7F800000;
    localparam logic [7:0]  ExpBias    = 8'd127;

    localparam logic [2:0] RmRne = 3'd0;
    localparam logic [2:0] RmRtz = 3'd1;
    localparam logic [2:0] RmRdn = 3'd2;
    localparam logic [2:0] RmRup = 3'd3;
    localparam logic [2:0] RmRmm = 3'd4;

    // Data moving from one root cell to the next.
    typedef struct packed {
        logic              valid;
        logic              special;
        logic [31:0]       spec_val;
        logic [2:0]        rm;
        logic [7:0]        exp;
        logic [53:0]       rad;
        logic [RemW-1:0]   rem;
        logic [NumSteps-1:0] q;
    } t_cell;
endpackage

FILE: rtl/float32_square_root.sv
// Top level of the float32 square root: unpack, 27 root cells, rounding.
// Depends on fsqrt_pkg, fsqrt_unpack, fsqrt_cell, fsqrt_round.
// Channel | Ports                             | Transfer
// input   | i_operand, i_rounding_mode        | start high and busy low
// result  | o_root                            | o_done high for one cycle
// One item enters every cycle; busy is always low.
// The pipeline has one unpack stage, one cell per root bit and one round stage.
// Reset is synchronous, active low, and clears the valid bits of all stages.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
`include "float32_square_root_assert.svh"
module float32_square_root (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_operand,
    input  logic [2:0]  i_rounding_mode,
    output logic        o_done,
    output logic [31:0] o_root
);
    localparam int unsigned N = fsqrt_pkg::NumSteps;
    fsqrt_pkg::t_cell chain [N+1];
    logic neg_root;

    assign busy = 1'b0;
    assign neg_root = o_done & o_root[31];

    fsqrt_unpack u_unpack (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start),
        .i_operand(i_operand), .i_rounding_mode(i_rounding_mode),
        .o_cell(chain[0])
    );

    for (genvar k = 0; k < N; k++) begin : g_cells
        fsqrt_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_cell(chain[k]), .o_cell(chain[k+1])
        );
    end

    fsqrt_round u_round (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cell(chain[N]),
        .o_done(o_done), .o_root(o_root)
    );

    `FSQ_ASSERT_NEXT(a_first_valid, i_clk, i_rst_n, start, chain[0].valid)
    `FSQ_ASSERT_NEXT(a_last_done, i_clk, i_rst_n, chain[N].valid, o_done)
    `FSQ_ASSERT_IMPL(a_special_sign, i_clk, i_rst_n, neg_root |-> (&o_root[30:23] || ~|o_root[30:0]))
endmodule

FILE: rtl/fsqrt_unpack.sv
// Front stage: special values, subnormal normalization and exponent halving.
// Depends on fsqrt_pkg.
`timescale 1ns / 1ps
module fsqrt_unpack (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [31:0]        i_operand,
    input  logic [2:0]         i_rounding_mode,
    output fsqrt_pkg::t_cell   o_cell
);
    logic        sign;
    logic [7:0]  e;
    logic [22:0] m;
    logic [4:0]  lz;
    logic [23:0] sig;
    logic signed [9:0] unb;
    logic signed [9:0] half;
    fsqrt_pkg::t_cell n_cell, r_cell;

    assign sign = i_operand[31];
    assign e    = i_operand[30:23];
    assign m    = i_operand[22:0];

    always_comb begin
        lz = 5'd22;
        for (int i = 0; i <= 22; i++) begin
            if (m[i]) lz = 5'(22 - i);
        end
    end

    always_comb begin
        n_cell = '0;
        n_cell.valid = i_valid;
        n_cell.rm = i_rounding_mode;
        if (e != 8'd0) begin
            sig = {1'b1, m};
            unb = $signed({2'b00, e}) - 10'sd127;
        end else begin
            sig = 24'({m, 1'b0} << lz);
            unb = -10'sd127 - $signed({5'd0, lz});
        end
        half = unb >>> 1;
        n_cell.exp = 8'(half + 10'sd127);
        n_cell.rad = unb[0] ? {sig, 30'd0} : {1'b0, sig, 29'd0};
        if (e == 8'hFF && m != 23'd0) begin
            n_cell.special = 1'b1;
            n_cell.spec_val = i_operand | 32'h00400000;
        end else if (e == 8'd0 && m == 23'd0) begin
            n_cell.special = 1'b1;
            n_cell.spec_val = {sign, 31'd0};
        end else if (sign) begin
            n_cell.special = 1'b1;
            n_cell.spec_val = fsqrt_pkg::RootNegNan;
        end else if (e == 8'hFF) begin
            n_cell.special = 1'b1;
            n_cell.spec_val = fsqrt_pkg::RootPosInf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
        end else begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;
endmodule

FILE: rtl/fsqrt_cell.sv
// One restoring root cell: produces one root bit per item and passes it on.
// Depends on fsqrt_pkg.
`timescale 1ns / 1ps
module fsqrt_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fsqrt_pkg::t_cell i_cell,
    output fsqrt_pkg::t_cell o_cell
);
    localparam int unsigned W = fsqrt_pkg::RemW + 2;
    logic [W-1:0] cur, trial;
    fsqrt_pkg::t_cell n_cell, r_cell;

    always_comb begin
        n_cell = i_cell;
        cur   = {i_cell.rem, i_cell.rad[53:52]};
        trial = {2'b00, i_cell.q, 2'b01};
        if (cur >= trial) begin
            n_cell.rem = fsqrt_pkg::RemW'(cur - trial);
            n_cell.q   = {i_cell.q[fsqrt_pkg::NumSteps-2:0], 1'b1};
        end else begin
            n_cell.rem = fsqrt_pkg::RemW'(cur);
            n_cell.q   = {i_cell.q[fsqrt_pkg::NumSteps-2:0], 1'b0};
        end
        n_cell.rad = {i_cell.rad[51:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
        end else begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;
endmodule

FILE: rtl/fsqrt_round.sv
// Final stage: rounding and packing of the result.
// Depends on fsqrt_pkg.
`timescale 1ns / 1ps
module fsqrt_round (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fsqrt_pkg::t_cell i_cell,
    output logic             o_done,
    output logic [31:0]      o_root
);
    logic [23:0] mant;
    logic g, r, s, up;
    logic [24:0] sum;
    logic [7:0]  ex;
    logic        r_done, n_done;
    logic [31:0] r_root, n_root;

    always_comb begin
        mant = i_cell.q[26:3];
        g = i_cell.q[2];
        r = i_cell.q[1];
        s = i_cell.q[0] | (i_cell.rem != '0);
        case (i_cell.rm)
            fsqrt_pkg::RmRne: up = g & (mant[0] | r | s);
            fsqrt_pkg::RmRup: up = g | r | s;
            fsqrt_pkg::RmRmm: up = g;
            default:          up = 1'b0;
        endcase
        sum = {1'b0, mant} + {24'd0, up};
        ex  = i_cell.exp + {7'd0, sum[24]};
        n_done = i_cell.valid;
        n_root = i_cell.special ? i_cell.spec_val : {1'b0, ex, sum[22:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= n_done;
        end
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

FILE: verif/float32_square_root_test.sv
// Self-checking testbench for the float32 square root pipeline.
// Depends on fsqrt_pkg and the float32_square_root top level.
`timescale 1ns / 1ps
module float32_square_root_test;
    localparam int unsigned Latency     = 29;
    localparam int unsigned WatchdogMax = 4000;
    localparam int unsigned RandomItems = 1200;

    typedef struct packed {
        logic [31:0] operand;
        logic [2:0]  rm;
    } t_sqrt_op;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_operand = '0;
    logic [2:0]  i_rounding_mode = '0;
    logic        o_done;
    logic [31:0] o_root;

    t_sqrt_op    pending_ops[$];
    logic [31:0] expected_roots[$];
    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned roots_checked = 0;
    int unsigned drain_at = 0;
    bit          stimulus_done = 1'b0;

    float32_square_root i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_operand(i_operand),
        .i_rounding_mode(i_rounding_mode),
        .o_done(o_done),
        .o_root(o_root)
    );

    always #2 i_clk = ~i_clk;

    // Bit-accurate square root: restoring digit recurrence, then rounding.
    function automatic logic [31:0] predict_root(input logic [31:0] a, input logic [2:0] rm);
        logic        sign;
        logic [7:0]  e;
        logic [22:0] m;
        logic [23:0] sig;
        int          unb;
        int          half;
        int          lz;
        logic [53:0] rad;
        logic [63:0] rem;
        logic [63:0] q;
        logic [63:0] cur;
        logic [63:0] trial;
        logic [23:0] mant;
        logic        g;
        logic        r;
        logic        s;
        logic        up;
        sign = a[31];
        e = a[30:23];
        m = a[22:0];
        if (e == 8'hFF && m != 0) return a | 32'h0040_0000;
        if (e == 0 && m == 0) return {sign, 31'b0};
        if (sign) return fsqrt_pkg::RootNegNan;
        if (e == 8'hFF) return fsqrt_pkg::RootPosInf;
        if (e != 0) begin
            sig = {1'b1, m};
            unb = int'(e) - 127;
        end else begin
            lz = 0;
            while (lz < 22 && m[22 - lz] == 1'b0) lz++;
            sig = 24'({m, 1'b0} << lz);
            unb = -127 - lz;
        end
        // Odd exponents shift one more bit so the halved exponent is exact.
        if (unb % 2 != 0) begin
            rad = 54'(sig) << 30;
            half = (unb - 1) / 2;
        end else begin
            rad = 54'(sig) << 29;
            half = unb / 2;
        end
        rem = 0;
        q = 0;
        for (int k = 0; k < 27; k++) begin
            cur = (rem << 2) | 64'(rad[53:52]);
            trial = (q << 2) | 64'd1;
            if (cur >= trial) begin
                rem = cur - trial;
                q = (q << 1) | 64'd1;
            end else begin
                rem = cur;
                q = q << 1;
            end
            rad = rad << 2;
        end
        mant = q[26:3];
        g = q[2];
        r = q[1];
        s = q[0] | (rem != 0);
        case (rm)
            fsqrt_pkg::RmRne: up = g & (mant[0] | r | s);
            fsqrt_pkg::RmRup: up = g | r | s;
            fsqrt_pkg::RmRmm: up = g;
            default: up = 1'b0;
        endcase
        half += 127;
        if (up) begin
            if (mant == 24'hFFFFFF) begin
                mant = 24'h800000;
                half++;
            end else begin
                mant++;
            end
        end
        return {1'b0, 8'(half), mant[22:0]};
    endfunction

    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(9))
            0: v[30:23] = 8'h00;
            1: v[30:23] = 8'hFF;
            2: v[22:0] = $urandom_range(1) ? 23'h7FFFFF : 23'h0;
            default: v[31] = ($urandom_range(7) == 0);
        endcase
        return v;
    endfunction

    initial begin
        logic [31:0] directed[$];
        directed = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0000, 32'h7F80_0001, 32'hFFBF_FFFF, 32'h0000_0001,
                     32'h007F_FFFF, 32'h8000_0001, 32'hBF80_0000, 32'h3F80_0000,
                     32'h4000_0000, 32'h7F7F_FFFF, 32'h0080_0000, 32'h4040_0000,
                     32'h3F7F_FFFF, 32'h0040_0000};
        foreach (directed[i])
            pending_ops.push_back('{directed[i], 3'(i % 8)});
        for (int k = 0; k < 8; k++)
            pending_ops.push_back('{32'h4000_0000, 3'(k)});
        for (int k = 0; k < RandomItems; k++)
            pending_ops.push_back('{random_operand(), 3'($urandom_range(7))});
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: bursts and gaps; halfway through it waits for the pipeline to drain.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_roots.push_back(predict_root(i_operand, i_rounding_mode));
                void'(pending_ops.pop_front());
            end
            if (pending_ops.size() == 0) begin
                start <= 1'b0;
                stimulus_done <= 1'b1;
            end else if (pending_ops.size() == RandomItems / 2 && expected_roots.size() != 0) begin
                start <= 1'b0;
            end else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else begin
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(40, 1);
                    gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
                end else begin
                    burst_left <= burst_left - 1;
                end
                start <= 1'b1;
                i_operand <= pending_ops[0].operand;
                i_rounding_mode <= pending_ops[0].rm;
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_roots.size() == 0) begin
                $error("root: unexpected result %h", o_root);
                error_count++;
            end else begin
                if (o_root !== expected_roots[0]) begin
                    $error("root: expected %h actual %h", expected_roots[0], o_root);
                    error_count++;
                end
                void'(expected_roots.pop_front());
                roots_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogMax) begin
            $display("float32_square_root verification failed");
            $finish;
        end else if (stimulus_done && expected_roots.size() == 0) begin
            drain_at <= drain_at + 1;
            if (drain_at == Latency + 4) begin
                $display("Checked %0d roots over all rounding modes and special operands.",
                         roots_checked);
                if (error_count == 0 && !o_done)
                    $display("float32_square_root verification clean");
                else
                    $display("float32_square_root verification failed");
                $finish;
            end
        end
    end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/fsqrt_pkg.sv
rtl/fsqrt_unpack.sv
rtl/fsqrt_cell.sv
rtl/fsqrt_round.sv
rtl/float32_square_root.sv
verif/float32_square_root_test.sv
